>>> design/bceg_pkg.sv
// Shared widths, constants, register indexes and control types of the battery gauge.
package bceg_pkg;

	localparam int VOLT_W     = 16;
	localparam int CUR_W      = 16;
	localparam int TIME_W     = 32;
	localparam int DT_W       = 16;
	localparam int CHG_W      = 39;
	localparam int NRG_W      = 56;
	localparam int DB_W       = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Charge capacity: half mA*ms per mAh; energy capacity: quarter uW*ms per mV*mAh
	localparam logic [22:0] CHG_PER_MAH    = 23'd7200000;
	localparam logic [23:0] NRG_PER_MV_MAH = 24'd14400000;

	localparam logic [VOLT_W-1:0] NOMINAL_RST  = 16'd3700;
	localparam logic [15:0]       CAPACITY_RST = 16'd2000;
	localparam logic [VOLT_W-1:0] FULL_RST     = 16'd4150;
	localparam logic [DB_W-1:0]   DEADBAND_RST = 10'd1;

	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL1 = 5'b00010,
		ST_MUL2 = 5'b00100,
		ST_ACC  = 5'b01000,
		ST_DONE = 5'b10000
	} bceg_state_t;

	typedef struct packed {
		logic load_in;
		logic mul1;
		logic mul2;
		logic acc;
		logic load_out;
	} bceg_cmd_t;

endpackage

>>> design/bceg_in_if.sv
// Input sample channel: valid/ready handshake with voltage, current and timestamp.
interface bceg_in_if;
	logic                                  valid;
	logic                                  ready;
	logic        [bceg_pkg::VOLT_W-1:0]    voltage_mv;
	logic signed [bceg_pkg::CUR_W-1:0]     current_ma;
	logic        [bceg_pkg::TIME_W-1:0]    time_ms;

	modport source (output valid, output voltage_mv, output current_ma, output time_ms,
		input ready);
	modport sink (input valid, input voltage_mv, input current_ma, input time_ms,
		output ready);
endinterface

>>> design/bceg_out_if.sv
// Result channel: valid/ready handshake with charge and energy levels and status flags.
interface bceg_out_if;
	logic                         valid;
	logic                         ready;
	logic [bceg_pkg::CHG_W-1:0]   charge_level;
	logic [bceg_pkg::NRG_W-1:0]   energy_level;
	logic                         charging;
	logic                         charged;

	modport source (output valid, output charge_level, output energy_level,
		output charging, output charged, input ready);
	modport sink (input valid, input charge_level, input energy_level,
		input charging, input charged, output ready);
endinterface

>>> design/battery_coulomb_energy_gauge.sv
// Top level of the battery coulomb and energy gauge.
// Each sample item (mV, signed mA, ms timestamp) is integrated over the saturated time
// step: charge by the trapezoid rule in half mA*ms, energy as summed voltage times summed
// current in quarter uW*ms, both clamped to capacities computed from the registers. The
// first sample and any full-battery sample load full capacity. The item is captured at its
// accepting edge and its result is made valid through two dependent multiply steps, the
// accumulate and the result load, set by the chain of two registered multiplies in the
// datapath; a new item is taken only once the last result is loaded, which waits while
// the result register still holds an untaken result.
// Configuration writes take effect on the next clock and must be made while idle.
module battery_coulomb_energy_gauge (
	input  logic                                   clk,
	input  logic                                   arst_n,
	bceg_in_if.sink                                in_ch,
	bceg_out_if.source                             out_ch,
	input  logic                                   cfg_we,
	input  logic [bceg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bceg_pkg::CFG_DATA_W-1:0]        cfg_data
);

	bceg_pkg::bceg_cmd_t cmd;

	bceg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	bceg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.voltage_mv   (in_ch.voltage_mv),
		.current_ma   (in_ch.current_ma),
		.time_ms      (in_ch.time_ms),
		.charge_level (out_ch.charge_level),
		.energy_level (out_ch.energy_level),
		.charging     (out_ch.charging),
		.charged      (out_ch.charged)
	);

endmodule

>>> design/bceg_ctrl.sv
// Controller state machine: sequences one sample through the datapath and owns the result valid.
module bceg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bceg_pkg::bceg_cmd_t cmd
);

	bceg_pkg::bceg_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  out_free;

	// Result register may be refilled when empty or being taken this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == bceg_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands from state
	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == bceg_pkg::ST_IDLE) && in_valid;
		cmd.mul1     = (state_q == bceg_pkg::ST_MUL1);
		cmd.mul2     = (state_q == bceg_pkg::ST_MUL2);
		cmd.acc      = (state_q == bceg_pkg::ST_ACC);
		cmd.load_out = (state_q == bceg_pkg::ST_DONE) && out_free;
	end

	// Advance state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bceg_pkg::ST_IDLE: begin
				if (in_valid) state_d = bceg_pkg::ST_MUL1;
			end
			bceg_pkg::ST_MUL1: state_d = bceg_pkg::ST_MUL2;
			bceg_pkg::ST_MUL2: state_d = bceg_pkg::ST_ACC;
			bceg_pkg::ST_ACC:  state_d = bceg_pkg::ST_DONE;
			bceg_pkg::ST_DONE: begin
				if (out_free) state_d = bceg_pkg::ST_IDLE;
			end
			default: state_d = bceg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bceg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == bceg_pkg::ST_MUL1))
		else $error("accepted item did not start the multiply sequence");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == bceg_pkg::ST_DONE))
		else $error("result valid rose outside the done state");

	a_acc_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bceg_pkg::ST_ACC) |=> (state_q == bceg_pkg::ST_DONE))
		else $error("accumulate step not followed by done");

endmodule

>>> design/bceg_dp.sv
// Datapath: configuration registers, time step, products, clamped accumulators, result payload.
module bceg_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  bceg_pkg::bceg_cmd_t                     cmd,
	input  logic                                    cfg_we,
	input  logic        [bceg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic        [bceg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic        [bceg_pkg::VOLT_W-1:0]      voltage_mv,
	input  logic signed [bceg_pkg::CUR_W-1:0]       current_ma,
	input  logic        [bceg_pkg::TIME_W-1:0]      time_ms,
	output logic        [bceg_pkg::CHG_W-1:0]       charge_level,
	output logic        [bceg_pkg::NRG_W-1:0]       energy_level,
	output logic                                    charging,
	output logic                                    charged
);

	// Configuration
	logic [15:0]                     nominal_q;
	logic [15:0]                     cap_mah_q;
	logic [15:0]                     full_q;
	logic [bceg_pkg::DB_W-1:0]       db_q;

	// Sample and history
	logic        [15:0]              in_v_q;
	logic signed [15:0]              in_i_q;
	logic        [31:0]              in_t_q;
	logic        [15:0]              last_v_q;
	logic signed [15:0]              last_i_q;
	logic        [31:0]              last_t_q;
	logic                            first_q;

	// Intermediate products
	logic        [bceg_pkg::DT_W-1:0] dt_q;
	logic signed [33:0]              pq_q;
	logic signed [34:0]              pvi_q;
	logic signed [51:0]              pe_q;
	logic        [bceg_pkg::CHG_W-1:0] capq_q;
	logic        [31:0]              vc_q;
	logic        [bceg_pkg::NRG_W-1:0] cape_q;
	logic                            charging_q;
	logic                            charged_q;

	// Accumulators and result payload
	logic        [bceg_pkg::CHG_W-1:0] charge_acc_q;
	logic        [bceg_pkg::NRG_W-1:0] energy_acc_q;
	logic        [bceg_pkg::CHG_W-1:0] charge_out_q;
	logic        [bceg_pkg::NRG_W-1:0] energy_out_q;
	logic                            charging_out_q;
	logic                            charged_out_q;

	// First-stage combinational terms
	logic        [31:0]              diff;
	logic        [bceg_pkg::DT_W-1:0] dt;
	logic signed [16:0]              isum;
	logic        [16:0]              vsum;
	logic signed [16:0]              i_ext;
	logic signed [16:0]              db_ext;

	// Accumulate-stage terms
	logic signed [40:0]              sum_c;
	logic signed [57:0]              sum_e;
	logic        [bceg_pkg::CHG_W-1:0] next_c;
	logic        [bceg_pkg::NRG_W-1:0] next_e;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q <= bceg_pkg::NOMINAL_RST;
			cap_mah_q <= bceg_pkg::CAPACITY_RST;
			full_q    <= bceg_pkg::FULL_RST;
			db_q      <= bceg_pkg::DEADBAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bceg_pkg::REG_NOMINAL:  nominal_q <= cfg_data;
				bceg_pkg::REG_CAPACITY: cap_mah_q <= cfg_data;
				bceg_pkg::REG_FULL:     full_q    <= cfg_data;
				bceg_pkg::REG_DEADBAND: db_q      <= cfg_data[bceg_pkg::DB_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_v_q <= voltage_mv;
			in_i_q <= current_ma;
			in_t_q <= time_ms;
		end
	end

	// Saturated time step, current and voltage sums, flags
	always_comb begin
		diff   = in_t_q - last_t_q;
		dt     = (|diff[31:16]) ? {bceg_pkg::DT_W{1'b1}} : diff[15:0];
		isum   = 17'(last_i_q) + 17'(in_i_q);
		vsum   = {1'b0, last_v_q} + {1'b0, in_v_q};
		i_ext  = 17'(in_i_q);
		db_ext = $signed({7'b0, db_q});
	end

	// First multiply stage; store this sample as the previous one
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			dt_q       <= dt;
			pq_q       <= 34'(isum) * $signed({1'b0, dt});
			pvi_q      <= $signed({1'b0, vsum}) * 35'(isum);
			capq_q     <= bceg_pkg::CHG_W'(cap_mah_q) * bceg_pkg::CHG_W'(bceg_pkg::CHG_PER_MAH);
			vc_q       <= 32'(nominal_q) * 32'(cap_mah_q);
			charging_q <= (i_ext >= -db_ext);
			charged_q  <= (in_v_q > full_q) && (i_ext > -db_ext) && (i_ext < db_ext);
			last_v_q   <= in_v_q;
			last_i_q   <= in_i_q;
			last_t_q   <= in_t_q;
		end
	end

	// Second multiply stage: energy delta and energy capacity
	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			pe_q   <= 52'(pvi_q) * $signed({1'b0, dt_q});
			cape_q <= bceg_pkg::NRG_W'(vc_q) * bceg_pkg::NRG_W'(bceg_pkg::NRG_PER_MV_MAH);
		end
	end

	// Integrate and clamp to [0, capacity]; reload on first sample or full battery
	always_comb begin
		sum_c = $signed({2'b00, charge_acc_q}) + 41'(pq_q);
		sum_e = $signed({2'b00, energy_acc_q}) + 58'(pe_q);
		if (sum_c < 0) begin
			next_c = '0;
		end else if (sum_c > $signed({2'b00, capq_q})) begin
			next_c = capq_q;
		end else begin
			next_c = sum_c[bceg_pkg::CHG_W-1:0];
		end
		if (sum_e < 0) begin
			next_e = '0;
		end else if (sum_e > $signed({2'b00, cape_q})) begin
			next_e = cape_q;
		end else begin
			next_e = sum_e[bceg_pkg::NRG_W-1:0];
		end
		if (first_q || charged_q) begin
			next_c = capq_q;
			next_e = cape_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			charge_acc_q <= next_c;
			energy_acc_q <= next_e;
		end
	end

	// Drop the first-sample mark once a sample has been integrated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (cmd.acc) begin
			first_q <= 1'b0;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			charge_out_q   <= charge_acc_q;
			energy_out_q   <= energy_acc_q;
			charging_out_q <= charging_q;
			charged_out_q  <= charged_q;
		end
	end

	assign charge_level = charge_out_q;
	assign energy_level = energy_out_q;
	assign charging     = charging_out_q;
	assign charged      = charged_out_q;

	a_charge_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |=> (charge_acc_q <= capq_q))
		else $error("charge level above capacity after accumulate");

	a_energy_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |=> (energy_acc_q <= cape_q))
		else $error("energy level above capacity after accumulate");

	a_charged_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc && charged_q) |=> (charge_acc_q == capq_q && energy_acc_q == cape_q))
		else $error("full battery did not reload both capacities");

endmodule

>>> tb/battery_coulomb_energy_gauge_tb.sv
// Self-checking testbench for the battery coulomb and energy gauge.
module battery_coulomb_energy_gauge_tb;
	import bceg_pkg::*;

	localparam longint CHARGE_PER_MAH    = 64'sd7200000;
	localparam longint ENERGY_PER_MV_MAH = 64'sd14400000;
	localparam longint MAX_STEP_MS       = 64'sd65535;
	localparam int     HOLD_OFF_CYCLES   = 120;
	localparam int     STALL_LIMIT       = 4000;
	localparam int     DRAIN_CYCLES      = 8;
	localparam int     MAX_PRINTED       = 100;

	typedef struct {
		logic        [VOLT_W-1:0] voltage_mv;
		logic signed [CUR_W-1:0]  current_ma;
		logic        [TIME_W-1:0] time_ms;
	} sample_t;

	typedef struct {
		logic [CHG_W-1:0] charge_level;
		logic [NRG_W-1:0] energy_level;
		logic             charging;
		logic             charged;
	} levels_t;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_COIN,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bceg_in_if  samples_ch();
	bceg_out_if levels_ch();

	battery_coulomb_energy_gauge dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(samples_ch),
		.out_ch(levels_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Register copies as the gauge should hold them
	logic [VOLT_W-1:0] gauge_nominal  = NOMINAL_RST;
	logic [15:0]       gauge_capacity = CAPACITY_RST;
	logic [VOLT_W-1:0] gauge_full     = FULL_RST;
	logic [DB_W-1:0]   gauge_deadband = DEADBAND_RST;

	// Gauge state as predicted
	logic        [VOLT_W-1:0] prev_voltage = '0;
	logic signed [CUR_W-1:0]  prev_current = '0;
	logic        [TIME_W-1:0] prev_time = '0;
	longint                   charge_q = 0;
	longint                   energy_q = 0;
	bit                       awaiting_first = 1'b1;

	sample_t pending_samples[$];
	levels_t expected_levels[$];

	logic [TIME_W-1:0] clock_ms = '0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	bit          hold_off_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned rx_mode_left = 0;
	int unsigned rx_tick = 0;
	rx_mode_t    rx_mode = RX_STEADY;
	int unsigned idle_cycles = 0;

	int mismatches = 0;
	int samples_taken = 0;
	int results_checked = 0;
	int charged_seen = 0;
	int empty_seen = 0;
	int settings_used = 1;

	function automatic longint limit_to_capacity(longint lvl, longint cap);
		if (lvl > cap)
			return cap;
		if (lvl < 0)
			return 0;
		return lvl;
	endfunction

	// Integrate one sample into the predicted state and form its result
	function automatic levels_t integrate_sample(sample_t s);
		levels_t r;
		longint cap_q, cap_e, db, cur, isum, vsum, step;
		logic [TIME_W-1:0] elapsed;
		cap_q = longint'(gauge_capacity) * CHARGE_PER_MAH;
		cap_e = longint'(gauge_nominal) * longint'(gauge_capacity) * ENERGY_PER_MV_MAH;
		db = longint'(gauge_deadband);
		cur = longint'(s.current_ma);
		if (awaiting_first) begin
			charge_q = cap_q;
			energy_q = cap_e;
			awaiting_first = 1'b0;
		end else begin
			elapsed = s.time_ms - prev_time;
			step = (elapsed > 32'd65535) ? MAX_STEP_MS : longint'(elapsed);
			isum = longint'(prev_current) + cur;
			vsum = longint'(prev_voltage) + longint'(s.voltage_mv);
			charge_q = limit_to_capacity(charge_q + isum * step, cap_q);
			energy_q = limit_to_capacity(energy_q + vsum * isum * step, cap_e);
		end
		prev_voltage = s.voltage_mv;
		prev_current = s.current_ma;
		prev_time = s.time_ms;
		r.charging = cur >= -db;
		r.charged = (s.voltage_mv > gauge_full) && (cur > -db) && (cur < db);
		// Full battery: reload both capacities
		if (r.charged) begin
			charge_q = cap_q;
			energy_q = cap_e;
		end
		r.charge_level = charge_q[CHG_W-1:0];
		r.energy_level = energy_q[NRG_W-1:0];
		return r;
	endfunction

	function automatic void push_sample(logic [15:0] v, logic [15:0] i, logic [31:0] t);
		sample_t s;
		s.voltage_mv = v;
		s.current_ma = i;
		s.time_ms = t;
		clock_ms = t;
		pending_samples.push_back(s);
	endfunction

	// Mostly plausible battery traffic, with noise, near-full samples and odd timestamps
	function automatic sample_t make_random_sample();
		sample_t s;
		int unsigned pick, step;
		int dbw;
		pick = $urandom_range(0, 99);
		dbw = int'(gauge_deadband) + 1;
		s.voltage_mv = 16'($urandom_range(3000, 4300));
		s.current_ma = 16'($urandom_range(0, 10000) - 5000);
		step = $urandom_range(0, 3000);
		if (pick < 10) begin
			s.voltage_mv = 16'($urandom);
			s.current_ma = 16'($urandom);
			clock_ms = $urandom;
			step = 0;
		end else if (pick < 28) begin
			s.voltage_mv = (gauge_full > 16'hFFFC) ? 16'hFFFF
				: gauge_full + 16'($urandom_range(0, 3));
			s.current_ma = 16'($urandom_range(0, 2 * dbw) - dbw);
		end else if (pick < 34) begin
			if ($urandom_range(0, 1))
				s.current_ma = 16'h7FFF;
			else
				s.current_ma = 16'h8000;
		end else if (pick < 44) begin
			step = $urandom_range(3000, 80000);
		end else if (pick < 49) begin
			step = 0 - $urandom_range(1, 5000);
		end else if (pick < 53) begin
			step = 0;
		end
		clock_ms = clock_ms + step;
		s.time_ms = clock_ms;
		return s;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatches < MAX_PRINTED)
			$display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
				results_checked, what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_NOMINAL: gauge_nominal = val;
			REG_CAPACITY: gauge_capacity = val;
			REG_FULL: gauge_full = val;
			REG_DEADBAND: gauge_deadband = val[DB_W-1:0];
			default: ;
		endcase
	endtask

	// Wait until every item is taken and every result has come back
	task automatic drain_samples();
		while (pending_samples.size() != 0 || samples_ch.valid)
			@(posedge clk);
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [15:0] nominal, logic [15:0] capacity, logic [15:0] full,
		logic [15:0] deadband, int count, bit squeeze);
		write_reg(REG_NOMINAL, nominal);
		write_reg(REG_CAPACITY, capacity);
		write_reg(REG_FULL, full);
		write_reg(REG_DEADBAND, deadband);
		settings_used++;
		if (squeeze)
			hold_off_req = 1'b1;
		repeat (count) pending_samples.push_back(make_random_sample());
		drain_samples();
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Send items in bursts separated by random gaps; hold an item until it is taken
	always @(posedge clk) begin : drive_samples
		logic taken;
		sample_t nxt;
		taken = samples_ch.valid && samples_ch.ready;
		if (!arst_n) begin
			samples_ch.valid <= 1'b0;
		end else begin
			if (taken)
				pending_samples.delete(0);
			if (!samples_ch.valid || taken) begin
				if (gap_left > 0) begin
					gap_left--;
					samples_ch.valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					nxt = pending_samples[0];
					samples_ch.valid <= 1'b1;
					samples_ch.voltage_mv <= nxt.voltage_mv;
					samples_ch.current_ma <= nxt.current_ma;
					samples_ch.time_ms <= nxt.time_ms;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					samples_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side on a changing pattern, with one long hold-off on request
	always @(posedge clk) begin : drive_ready
		logic rdy;
		if (!arst_n) begin
			levels_ch.ready <= 1'b0;
		end else begin
			rx_tick++;
			if (hold_off_req && hold_left == 0) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_mode_left = $urandom_range(16, 160);
				end
				rx_mode_left--;
				case (rx_mode)
					RX_STEADY: rdy = 1'b1;
					RX_COIN: rdy = 1'($urandom_range(0, 1));
					RX_PERIODIC: rdy = (rx_tick % 5) >= 2;
					default: rdy = $urandom_range(0, 7) != 0;
				endcase
			end
			levels_ch.ready <= rdy;
		end
	end

	// Predict on each accepted sample, compare each accepted result
	always @(posedge clk) begin : check_levels
		sample_t taken_sample;
		levels_t want;
		if (arst_n) begin
			if (samples_ch.valid && samples_ch.ready) begin
				taken_sample.voltage_mv = samples_ch.voltage_mv;
				taken_sample.current_ma = samples_ch.current_ma;
				taken_sample.time_ms = samples_ch.time_ms;
				expected_levels.push_back(integrate_sample(taken_sample));
				samples_taken++;
			end
			if (levels_ch.valid && levels_ch.ready) begin
				if (expected_levels.size() == 0) begin
					report_mismatch("result with no sample", 64'd0, 64'd0);
				end else begin
					want = expected_levels.pop_front();
					if (levels_ch.charge_level !== want.charge_level)
						report_mismatch("charge_level", levels_ch.charge_level, want.charge_level);
					if (levels_ch.energy_level !== want.energy_level)
						report_mismatch("energy_level", levels_ch.energy_level, want.energy_level);
					if (levels_ch.charging !== want.charging)
						report_mismatch("charging", levels_ch.charging, want.charging);
					if (levels_ch.charged !== want.charged)
						report_mismatch("charged", levels_ch.charged, want.charged);
					if (want.charged)
						charged_seen++;
					if (want.charge_level == '0)
						empty_seen++;
				end
				results_checked++;
			end
		end
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin : watchdog
		if ((samples_ch.valid && samples_ch.ready) || (levels_ch.valid && levels_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == STALL_LIMIT) begin
			$display("no item moved for %0d cycles", STALL_LIMIT);
			$display("battery_coulomb_energy_gauge_tb: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int ph;
		logic [15:0] cap;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_ch.valid = 1'b0;
		samples_ch.voltage_mv = '0;
		samples_ch.current_ma = '0;
		samples_ch.time_ms = '0;
		levels_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed samples under reset register values
		push_sample(16'd3800, 16'd500, 32'd1000);            // first sample loads full
		push_sample(16'd3790, 16'(-1500), 32'd2000);
		push_sample(16'hFFFF, 16'h7FFF, 32'd67535);          // step of exactly 65535 ms
		push_sample(16'd0, 16'h8000, 32'd133071);            // long gap saturates
		push_sample(16'd3700, 16'd0, 32'd133061);            // timestamp goes backwards
		push_sample(16'd3700, 16'(-300), 32'd133061);        // zero step
		push_sample(16'd4151, 16'd0, 32'd134000);            // full battery reload
		push_sample(16'd4150, 16'd0, 32'd135000);            // at threshold, not full
		push_sample(16'd5000, 16'd1, 32'd136000);            // edge of deadband, charging
		push_sample(16'd5000, 16'(-1), 32'd137000);
		push_sample(16'd4200, 16'(-2), 32'd138000);          // discharging
		push_sample(16'd3600, 16'(-700), 32'hFFFF_FFF0);
		push_sample(16'd3600, 16'(-700), 32'h0000_0010);     // timestamp wraps
		push_sample(16'd3600, 16'd0, 32'hFFFF_FFFF);
		repeat (4) push_sample(16'd3000, 16'h8000, clock_ms + 32'd65535);  // drain to empty
		repeat (4) push_sample(16'd4100, 16'h7FFF, clock_ms + 32'd65535);  // charge at full current
		drain_samples();

		// Extremes, then the capacity lowered to nothing
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 1'b0);
		run_phase(16'h0000, 16'h0000, 16'h0000, 16'h0000, 60, 1'b0);

		// Random settings, small capacities often so the levels swing
		for (ph = 0; ph < 6; ph++) begin
			cap = (ph % 2 == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom);
			run_phase(16'($urandom), cap, 16'($urandom_range(3900, 4300)),
				(ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)), 85, ph == 2);
		end

		repeat (20) @(posedge clk);
		$display("checked %0d results from %0d samples over %0d register settings",
			results_checked, samples_taken, settings_used);
		$display("%0d full-battery reloads, %0d results with an empty charge level",
			charged_seen, empty_seen);
		if (mismatches == 0)
			$display("battery_coulomb_energy_gauge_tb: PASS");
		else
			$display("battery_coulomb_energy_gauge_tb: FAIL");
		$finish;
	end

endmodule

>>> files.f
design/bceg_pkg.sv
design/bceg_in_if.sv
design/bceg_out_if.sv
design/bceg_ctrl.sv
design/bceg_dp.sv
design/battery_coulomb_energy_gauge.sv
tb/battery_coulomb_energy_gauge_tb.sv
